### rtl/tilt_stabilization_filter_core_assert.svh
// Assertion macros for the tilt stabilization filter core.
// Define ASSERT_OFF to compile the checks out.
`ifndef TILT_STABILIZATION_FILTER_CORE_ASSERT_SVH
`define TILT_STABILIZATION_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge.
`define TSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsf: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define TSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsf: next-cycle check failed");

`else

`define TSF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TSF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/tsf_pkg.sv
package tsf_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RAD_ROLL,
        S_RAD_PITCH,
        S_DIFF,
        S_BLEND_ROLL,
        S_BLEND_PITCH,
        S_DONE
    } tsf_state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEADBAND = 2'd0;
    localparam logic [1:0] CFG_MAX_TILT = 2'd1;
    localparam logic [1:0] CFG_TAU      = 2'd2;
    localparam logic [1:0] CFG_SWAP     = 2'd3;

    // Configuration reset values
    localparam logic [14:0] DEADBAND_RST = 15'd512;
    localparam logic [14:0] MAX_TILT_RST = 15'd5120;
    localparam logic [13:0] TAU_RST      = 14'd200;

    // Time step handling, ms
    localparam logic [5:0] DT_DEFAULT_MS = 6'd20;
    localparam logic [5:0] DT_MAX_MS     = 6'd50;

    // round(pi/180 * 2^32)
    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

    // Alpha divider: 22-bit dividend, one quotient bit per step
    localparam int unsigned DIV_WIDTH = 22;
    localparam logic [4:0]  DIV_LAST  = 5'(DIV_WIDTH - 1);

    localparam logic signed [21:0] OUT_MAX = 22'sd524287;
    localparam logic signed [21:0] OUT_MIN = -22'sd524288;

endpackage

### rtl/tilt_stabilization_filter_core.sv
// Tilt stabilization filter core: deadband, clamp and first-order low-pass.
// A new sample is accepted only in the idle state, after the previous result has
// been handed to the output register; each one runs through the 22-step restoring
// divider that forms alpha and the shared 21x27 multiplier used four times.
// Reset (aresetn low, synchronous): filter state and timestamp cleared,
// configuration registers return to their defaults, output channel empty.
`include "tilt_stabilization_filter_core_assert.svh"

module tilt_stabilization_filter_core
    import tsf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,

    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_roll_deg,
    input  logic signed [15:0] s_pitch_deg,
    input  logic [31:0]        s_now_ms,

    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [19:0] m_body_pitch_rad,
    output logic signed [19:0] m_body_roll_rad
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Zero an axis inside the deadband, then clamp it to +/- lim.
    function automatic logic signed [15:0] shape_axis(
        input logic signed [15:0] x,
        input logic [14:0]        db,
        input logic [14:0]        lim
    );
        logic signed [16:0] xe;
        logic signed [16:0] neg_x;
        logic [16:0]        mag;
        logic signed [16:0] lims;
        logic signed [16:0] res;
        xe    = {x[15], x};
        neg_x = -xe;
        mag   = xe[16] ? neg_x : xe;
        lims  = $signed({2'b00, lim});
        res   = (mag < {2'b00, db}) ? '0 : xe;
        if (res > lims) begin
            res = lims;
        end else if (res < -lims) begin
            res = -lims;
        end
        return res[15:0];
    endfunction

    // Magnitude of a shaped axis (range is +/-32767, so 15 bits suffice).
    function automatic logic [14:0] axis_mag(input logic signed [15:0] x);
        logic signed [15:0] neg_x;
        neg_x = -x;
        return x[15] ? neg_x[14:0] : x[14:0];
    endfunction

    // Apply a rounded step to the filter state and saturate to 20 bits.
    function automatic logic signed [19:0] blend_update(
        input logic signed [19:0] y,
        input logic               neg,
        input logic [47:0]        prod
    );
        logic [20:0]        step;
        logic signed [21:0] y22;
        logic signed [21:0] sum;
        step = prod[36:16] + {20'b0, prod[15]};
        y22  = {{2{y[19]}}, y};
        sum  = neg ? (y22 - $signed({1'b0, step})) : (y22 + $signed({1'b0, step}));
        if (sum > OUT_MAX) begin
            sum = OUT_MAX;
        end else if (sum < OUT_MIN) begin
            sum = OUT_MIN;
        end
        return sum[19:0];
    endfunction

    // Rounded radians from a degree product, with the axis sign restored.
    function automatic logic signed [18:0] rad_target(
        input logic        neg,
        input logic [47:0] prod
    );
        logic [17:0]        r;
        logic signed [18:0] rs;
        r  = prod[41:24] + {17'b0, prod[23]};
        rs = $signed({1'b0, r});
        return neg ? -rs : rs;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers: always ready; user must write only when idle
    // ------------------------------------------------------------------
    logic [14:0] deadband_reg;
    logic [14:0] max_tilt_reg;
    logic [13:0] tau_reg;
    logic        swap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RST;
            max_tilt_reg <= MAX_TILT_RST;
            tau_reg      <= TAU_RST;
            swap_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DEADBAND: deadband_reg <= cfg_data;
                CFG_MAX_TILT: max_tilt_reg <= cfg_data;
                CFG_TAU:      tau_reg      <= cfg_data[13:0];
                CFG_SWAP:     swap_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    tsf_state_t state_reg, state_next;
    logic [4:0] div_cnt_reg;

    logic       accept;
    logic       out_free;

    // control decoded from the state
    logic       div_step;
    logic       mul_en;
    logic       load_alpha;
    logic       load_tgt_roll;
    logic       load_diff;
    logic       upd_roll;
    logic       finish;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DIV;
            end
            S_DIV: begin
                if (div_cnt_reg == DIV_LAST) state_next = S_RAD_ROLL;
            end
            S_RAD_ROLL:    state_next = S_RAD_PITCH;
            S_RAD_PITCH:   state_next = S_DIFF;
            S_DIFF:        state_next = S_BLEND_ROLL;
            S_BLEND_ROLL:  state_next = S_BLEND_PITCH;
            S_BLEND_PITCH: state_next = S_DONE;
            S_DONE: begin
                // hold the finished result until the output register is free
                if (out_free) state_next = S_IDLE;
            end
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        div_step      = 1'b0;
        mul_en        = 1'b0;
        load_alpha    = 1'b0;
        load_tgt_roll = 1'b0;
        load_diff     = 1'b0;
        upd_roll      = 1'b0;
        finish        = 1'b0;
        unique case (state_reg)
            S_IDLE:        s_ready = 1'b1;
            S_DIV:         div_step = 1'b1;
            S_RAD_ROLL: begin
                mul_en     = 1'b1;
                load_alpha = 1'b1;
            end
            S_RAD_PITCH: begin
                mul_en        = 1'b1;
                load_tgt_roll = 1'b1;
            end
            S_DIFF:        load_diff = 1'b1;
            S_BLEND_ROLL:  mul_en = 1'b1;
            S_BLEND_PITCH: begin
                mul_en   = 1'b1;
                upd_roll = 1'b1;
            end
            S_DONE:        finish = out_free;
            default:       ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                div_cnt_reg <= '0;
            end else if (div_step) begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Intake: axis swap, deadband, clamp, time step
    // ------------------------------------------------------------------
    logic signed [15:0] roll_sel, pitch_sel;
    logic signed [15:0] roll_shaped, pitch_shaped;
    logic [31:0]        elapsed;
    logic [5:0]         dt;
    logic [14:0]        den_in;
    logic [21:0]        num_in;

    assign roll_sel     = swap_reg ? s_pitch_deg : s_roll_deg;
    assign pitch_sel    = swap_reg ? s_roll_deg  : s_pitch_deg;
    assign roll_shaped  = shape_axis(roll_sel,  deadband_reg, max_tilt_reg);
    assign pitch_shaped = shape_axis(pitch_sel, deadband_reg, max_tilt_reg);

    // A stored timestamp of zero means no previous sample.
    logic [31:0] last_time_reg;

    assign elapsed = s_now_ms - last_time_reg;

    always_comb begin
        if (last_time_reg == '0) begin
            dt = DT_DEFAULT_MS;
        end else if (elapsed > 32'(DT_MAX_MS)) begin
            dt = DT_MAX_MS;
        end else begin
            dt = elapsed[5:0];
        end
    end

    // alpha = (dt * 2^16 + den/2) / den
    assign den_in = {1'b0, tau_reg} + 15'(dt);
    assign num_in = {dt, 16'b0} + 22'(den_in[14:1]);

    logic              roll_neg_reg, pitch_neg_reg;
    logic [14:0]       roll_mag_reg, pitch_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
        end else if (accept) begin
            last_time_reg <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            roll_neg_reg  <= roll_shaped[15];
            pitch_neg_reg <= pitch_shaped[15];
            roll_mag_reg  <= axis_mag(roll_shaped);
            pitch_mag_reg <= axis_mag(pitch_shaped);
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: one quotient bit per cycle. The dividend shifts
    // out of quo_reg from the top while quotient bits shift in below.
    // ------------------------------------------------------------------
    logic [14:0] den_reg;
    logic [14:0] rem_reg;
    logic [21:0] quo_reg;
    logic [15:0] trial;
    logic        trial_ge;
    logic [15:0] trial_diff;

    assign trial      = {rem_reg, quo_reg[21]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (accept) begin
            den_reg <= den_in;
            rem_reg <= '0;
            quo_reg <= num_in;
        end else if (div_step) begin
            rem_reg <= trial_ge ? trial_diff[14:0] : trial[14:0];
            quo_reg <= {quo_reg[20:0], trial_ge};
        end
    end

    // Saturate alpha to Q0.16; a zero divisor gives zero.
    logic [15:0] alpha_reg;
    logic [15:0] alpha_next;

    always_comb begin
        if (den_reg == '0) begin
            alpha_next = '0;
        end else if (quo_reg[21:16] != '0) begin
            alpha_next = '1;
        end else begin
            alpha_next = quo_reg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_alpha) alpha_reg <= alpha_next;
    end

    // ------------------------------------------------------------------
    // Shared multiplier: degree-to-radian scaling, then the blend steps.
    // ------------------------------------------------------------------
    logic [20:0] mul_a;
    logic [26:0] mul_b;
    logic [47:0] prod_reg;

    logic              dr_neg_reg, dp_neg_reg;
    logic [20:0]       dr_mag_reg, dp_mag_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RAD_ROLL: begin
                mul_a = 21'(roll_mag_reg);
                mul_b = DEG2RAD_Q32;
            end
            S_RAD_PITCH: begin
                mul_a = 21'(pitch_mag_reg);
                mul_b = DEG2RAD_Q32;
            end
            S_BLEND_ROLL: begin
                mul_a = dr_mag_reg;
                mul_b = 27'(alpha_reg);
            end
            S_BLEND_PITCH: begin
                mul_a = dp_mag_reg;
                mul_b = 27'(alpha_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) prod_reg <= 48'(mul_a) * 48'(mul_b);
    end

    // ------------------------------------------------------------------
    // Targets and differences against the stored filter state
    // ------------------------------------------------------------------
    logic signed [18:0] tgt_roll_reg;
    logic signed [18:0] tgt_pitch;
    logic signed [19:0] roll_f_reg, pitch_f_reg;
    logic signed [20:0] diff_roll, diff_pitch;
    logic signed [20:0] ndiff_roll, ndiff_pitch;

    assign tgt_pitch   = rad_target(pitch_neg_reg, prod_reg);
    assign diff_roll   = {{2{tgt_roll_reg[18]}}, tgt_roll_reg} - {roll_f_reg[19], roll_f_reg};
    assign diff_pitch  = {{2{tgt_pitch[18]}}, tgt_pitch} - {pitch_f_reg[19], pitch_f_reg};
    assign ndiff_roll  = -diff_roll;
    assign ndiff_pitch = -diff_pitch;

    always_ff @(posedge aclk) begin
        if (load_tgt_roll) tgt_roll_reg <= rad_target(roll_neg_reg, prod_reg);
        if (load_diff) begin
            dr_neg_reg <= diff_roll[20];
            dp_neg_reg <= diff_pitch[20];
            dr_mag_reg <= diff_roll[20]  ? ndiff_roll  : diff_roll;
            dp_mag_reg <= diff_pitch[20] ? ndiff_pitch : diff_pitch;
        end
    end

    // Filter state; advance roll first, pitch when the result is handed over.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_f_reg  <= '0;
            pitch_f_reg <= '0;
        end else begin
            if (upd_roll) roll_f_reg  <= blend_update(roll_f_reg, dr_neg_reg, prod_reg);
            if (finish)   pitch_f_reg <= blend_update(pitch_f_reg, dp_neg_reg, prod_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic               m_valid_reg;
    logic signed [19:0] m_pitch_reg, m_roll_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_pitch_reg <= blend_update(pitch_f_reg, dp_neg_reg, prod_reg);
            m_roll_reg  <= roll_f_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_body_pitch_rad = m_pitch_reg;
    assign m_body_roll_rad  = m_roll_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TSF_ASSERT_NXT(a_accept_starts_div, aclk, aresetn, accept, state_reg == S_DIV)
    `TSF_ASSERT_NXT(a_div_ends, aclk, aresetn, (state_reg == S_DIV) && (div_cnt_reg == DIV_LAST), state_reg == S_RAD_ROLL)
    `TSF_ASSERT_NXT(a_done_holds, aclk, aresetn, (state_reg == S_DONE) && m_valid && !m_ready, state_reg == S_DONE)
    `TSF_ASSERT_IMP(a_result_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == S_DONE)

endmodule
